>>> src/edist_pkg.sv
// Shared types and command codes for the edit distance engine.
// No dependencies; used by edit_distance_engine_core.
package edist_pkg;

  localparam int CMD_W = 2;
  localparam int CH_W  = 8;
  localparam int DST_W = 8;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0]  ch;
  } item_t;

  typedef struct packed {
    logic [DST_W-1:0] distance;
    logic             error;
  } result_t;

endpackage

>>> src/edit_distance_engine_core.sv
// Levenshtein edit distance engine: a chain of MAX_LEN cells, one per
// first-string character. Load and step items are taken one per cycle; a step
// item's token walks the chain, one cell per cycle, to the tail.
// A finish item waits until no token is left in the chain and the output slot
// is free; its result is registered when the finish item is accepted.
// Synchronous reset clears lengths, error flag, cell occupancy and output valid.
module edit_distance_engine_core #(
  parameter int MAX_LEN = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  edist_pkg::item_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output edist_pkg::result_t result
);

  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] first_length;
  logic [CW-1:0] second_length;
  logic          error_seen;
  logic [CW-1:0] pending;
  logic [CW-1:0] last_val;

  logic          accept;
  logic          do_load;
  logic          do_step;
  logic          do_finish;
  logic          load_bad;
  logic          step_bad;
  logic          tail_exit;
  logic [CW-1:0] final_dist;

  logic          tok_valid [MAX_LEN+1];
  logic [7:0]    tok_ch    [MAX_LEN+1];
  logic [CW-1:0] tok_new   [MAX_LEN+1];
  logic [CW-1:0] tok_old   [MAX_LEN+1];

  // Hold a finish item until the chain drains and the output slot is free
  assign item_stall = (item.cmd == edist_pkg::CMD_FINISH) &&
                      ((pending != '0) || (result_valid && result_stall));
  assign accept     = item_valid && !item_stall;

  assign load_bad  = (second_length != '0) || (first_length == CW'(MAX_LEN));
  assign step_bad  = (second_length == CW'(MAX_LEN));
  assign do_load   = accept && (item.cmd == edist_pkg::CMD_LOAD) && !load_bad;
  assign do_step   = accept && (item.cmd == edist_pkg::CMD_STEP) && !step_bad;
  assign do_finish = accept && (item.cmd == edist_pkg::CMD_FINISH);
  assign tail_exit = tok_valid[MAX_LEN];

  // Inject the step token at the head of the chain
  assign tok_valid[0] = do_step;
  assign tok_ch[0]    = item.ch;
  assign tok_new[0]   = second_length + CW'(1);
  assign tok_old[0]   = second_length;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    edist_cell #(
      .CW (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (do_finish),
      .load      (do_load && (first_length == CW'(i))),
      .load_ch   (item.ch),
      .load_val  (first_length + CW'(1)),
      .in_valid  (tok_valid[i]),
      .in_ch     (tok_ch[i]),
      .in_new    (tok_new[i]),
      .in_old    (tok_old[i]),
      .out_valid (tok_valid[i+1]),
      .out_ch    (tok_ch[i+1]),
      .out_new   (tok_new[i+1]),
      .out_old   (tok_old[i+1])
    );
  end

  // Track lengths, error flag and tokens in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      first_length  <= '0;
      second_length <= '0;
      error_seen    <= 1'b0;
      pending       <= '0;
    end else begin
      if (do_finish) begin
        first_length  <= '0;
        second_length <= '0;
        error_seen    <= 1'b0;
      end else begin
        if (do_load) begin
          first_length <= first_length + CW'(1);
        end
        if (do_step) begin
          second_length <= second_length + CW'(1);
        end
        if (accept && (((item.cmd == edist_pkg::CMD_LOAD) && load_bad) ||
                       ((item.cmd == edist_pkg::CMD_STEP) && step_bad))) begin
          error_seen <= 1'b1;
        end
      end
      if (do_step && !tail_exit) begin
        pending <= pending + CW'(1);
      end else if (!do_step && tail_exit) begin
        pending <= pending - CW'(1);
      end
    end
  end

  // Capture the last column entry as each token leaves the chain
  always_ff @(posedge clk) begin
    if (tail_exit) begin
      last_val <= tok_new[MAX_LEN];
    end
  end

  // With no second string the entry is still the first length
  assign final_dist = (second_length == '0) ? first_length : last_val;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (do_finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      result.distance <= error_seen ? '0 : edist_pkg::DST_W'(final_dist);
      result.error    <= error_seen;
    end
  end

endmodule

>>> src/edist_cell.sv
// One systolic cell of the edit distance chain: holds one first-string
// character and its column entry. Standalone, no package dependencies.
module edist_cell #(
  parameter int CW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          load,
  input  logic [7:0]    load_ch,
  input  logic [CW-1:0] load_val,
  input  logic          in_valid,
  input  logic [7:0]    in_ch,
  input  logic [CW-1:0] in_new,
  input  logic [CW-1:0] in_old,
  output logic          out_valid,
  output logic [7:0]    out_ch,
  output logic [CW-1:0] out_new,
  output logic [CW-1:0] out_old
);

  logic          active;
  logic [7:0]    letter;
  logic [CW-1:0] entry;

  logic [CW:0]   up_cost;
  logic [CW:0]   left_cost;
  logic [CW:0]   diag_cost;
  logic [CW:0]   min_ul;
  logic [CW:0]   best_w;
  logic [CW-1:0] best;

  // Pick the cheapest of insert, delete and substitute
  always_comb begin
    up_cost   = {1'b0, entry} + (CW+1)'(1);
    left_cost = {1'b0, in_new} + (CW+1)'(1);
    diag_cost = {1'b0, in_old} + ((letter == in_ch) ? (CW+1)'(0) : (CW+1)'(1));
    min_ul    = (up_cost < left_cost) ? up_cost : left_cost;
    best_w    = (min_ul < diag_cost) ? min_ul : diag_cost;
    best      = best_w[CW-1:0];
  end

  // Track occupancy and the token valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clear) begin
        active <= 1'b0;
      end else if (load) begin
        active <= 1'b1;
      end
      out_valid <= in_valid;
    end
  end

  // Load or update the column entry; hand the token to the next cell
  always_ff @(posedge clk) begin
    if (load) begin
      letter <= load_ch;
      entry  <= load_val;
    end else if (in_valid && active) begin
      entry <= best;
    end
    out_ch  <= in_ch;
    out_new <= active ? best : in_new;
    out_old <= active ? entry : in_old;
  end

endmodule
